>>> design/ffe_pkg.sv
// ----------------------------------------------------------------------------
// ffe_pkg: shared types and constants
// Action codes, panel command bytes and the front-to-back request struct.
// ----------------------------------------------------------------------------
package ffe_pkg;

  localparam logic [2:0] ACT_DRAW   = 3'd0;
  localparam logic [2:0] ACT_RECT   = 3'd1;
  localparam logic [2:0] ACT_SCREEN = 3'd2;
  localparam logic [2:0] ACT_WINDOW = 3'd3;
  localparam logic [2:0] ACT_EMIT   = 3'd4;

  localparam logic [7:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [7:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [7:0] CMD_MEMORY_WRITE = 8'h2C;
  localparam logic [7:0] BYTE_MASK        = 8'hFF;

  localparam int unsigned CW = 11;  // coordinate width, covers screen sizes to 2048

  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,   // fill clipped rectangle (draw and screen fill too)
    OP_WINDOW = 2'd1,
    OP_EMIT   = 2'd2,
    OP_CLEAR  = 2'd3    // empty window: drop busy
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [CW-1:0]   x0;
    logic [CW-1:0]   y0;
    logic [CW-1:0]   x1;   // inclusive
    logic [CW-1:0]   y1;   // inclusive
    logic [15:0]     color;
  } req_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FILL,
    BK_HDR,
    BK_RD,
    BK_PX_HI,
    BK_PX_LO,
    BK_CLR
  } bk_state_t;

endpackage

>>> design/ffe_if.sv
// ----------------------------------------------------------------------------
// ffe_in_if / ffe_out_if / ffe_cfg_if: valid-ready channels
// Request, result and configuration channels of the flush engine.
// ----------------------------------------------------------------------------
interface ffe_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [11:0] rect_width;
  logic signed [11:0] rect_height;
  logic [15:0]        pixel_color;
  modport source (output valid, action, pos_x, pos_y, rect_width, rect_height,
                  pixel_color, input ready);
  modport sink (input valid, action, pos_x, pos_y, rect_width, rect_height,
                pixel_color, output ready);
endinterface

interface ffe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_data;
  logic       run_last;
  logic       window_done;
  modport source (output valid, out_byte, is_data, run_last, window_done,
                  input ready);
  modport sink (input valid, out_byte, is_data, run_last, window_done,
                output ready);
endinterface

interface ffe_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> design/ffe_front.sv
// ----------------------------------------------------------------------------
// ffe_front: request decode and clipping
// Classifies each action, clips rectangles to the screen and registers one
// request for the queue.
// ----------------------------------------------------------------------------
module ffe_front import ffe_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 170
) (
  input  logic        clk,
  input  logic        rst_n,
  ffe_in_if.sink      in_ch,
  output logic        req_valid,
  input  logic        req_ready,
  output req_t        req
);

  logic          vld_r;
  req_t          req_r;
  req_t          req_nxt;
  logic          keep;
  logic signed [13:0] x, y, xe, ye, xa, ya, xb, yb;

  assign in_ch.ready = !vld_r || req_ready;
  assign req_valid   = vld_r;
  assign req         = req_r;

  always_comb begin
    x  = 14'(in_ch.pos_x);
    y  = 14'(in_ch.pos_y);
    xe = x + 14'(in_ch.rect_width);
    ye = y + 14'(in_ch.rect_height);
    if (in_ch.action == ACT_DRAW) begin
      xe = x + 14'sd1;
      ye = y + 14'sd1;
    end
    xa = (x < 0) ? 14'sd0 : x;
    ya = (y < 0) ? 14'sd0 : y;
    xb = (xe > 14'(SCREEN_WIDTH))  ? 14'(SCREEN_WIDTH)  : xe;
    yb = (ye > 14'(SCREEN_HEIGHT)) ? 14'(SCREEN_HEIGHT) : ye;
    keep = (xb > xa) && (yb > ya);
    req_nxt.color = in_ch.pixel_color;
    req_nxt.x0 = xa[CW-1:0];
    req_nxt.y0 = ya[CW-1:0];
    req_nxt.x1 = CW'(xb - 14'sd1);
    req_nxt.y1 = CW'(yb - 14'sd1);
    req_nxt.op = OP_FILL;
    unique case (in_ch.action)
      ACT_DRAW, ACT_RECT: req_nxt.op = OP_FILL;
      ACT_SCREEN: begin
        req_nxt.op = OP_FILL;
        req_nxt.x0 = '0;
        req_nxt.y0 = '0;
        req_nxt.x1 = CW'(SCREEN_WIDTH - 1);
        req_nxt.y1 = CW'(SCREEN_HEIGHT - 1);
        keep = 1'b1;
      end
      ACT_WINDOW: begin
        req_nxt.op = keep ? OP_WINDOW : OP_CLEAR;
        keep = 1'b1;
      end
      ACT_EMIT: begin
        req_nxt.op = OP_EMIT;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      vld_r <= in_ch.valid && keep;
    end
    if (in_ch.ready && in_ch.valid) begin
      req_r <= req_nxt;
    end
  end

endmodule

>>> design/ffe_queue.sv
// ----------------------------------------------------------------------------
// ffe_queue: request queue
// Two-entry queue between the decode and execution halves.
// ----------------------------------------------------------------------------
module ffe_queue import ffe_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  req_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output req_t rd_data
);

  req_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end

endmodule

>>> design/ffe_back.sv
// ----------------------------------------------------------------------------
// ffe_back: frame store and byte sequencer
// Holds the frame store, walks fills one pixel a cycle, clears the store
// after reset, and emits window headers and pixel bytes.
// ----------------------------------------------------------------------------
module ffe_back import ffe_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 170
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [8:0]  row_offset,
  input  logic        req_valid,
  output logic        req_ready,
  input  req_t        req,
  ffe_out_if.source   out_ch
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rd_data_r;

  bk_state_t     state_r, state_nxt;
  req_t          cur_r;
  logic [CW-1:0] col_r, row_r;
  logic [AW-1:0] addr_r;
  logic [3:0]    hdr_r;
  logic          busy_r;
  logic [CW-1:0] wl_r, wt_r, wr_r, wb_r;   // window left, top, right - left, bottom - top
  logic [CW-1:0] cc_r, cr_r;               // emit cursor
  logic          done_r;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [AW-1:0] rd_addr;
  logic [11:0]   ry0, ry1;
  logic [7:0]    hb;
  logic          hd;
  logic          fire;

  assign fire = out_ch.valid && out_ch.ready;
  assign ry0  = 12'(cur_r.y0) + 12'(row_offset);
  assign ry1  = 12'(cur_r.y1) + 12'(row_offset);

  // window header byte
  always_comb begin
    hb = CMD_COLUMN_SET;
    hd = 1'b1;
    case (hdr_r)
      4'd0:  begin hb = CMD_COLUMN_SET; hd = 1'b0; end
      4'd1:  hb = 8'(16'(cur_r.x0) >> 8);
      4'd2:  hb = 8'(cur_r.x0) & BYTE_MASK;
      4'd3:  hb = 8'(16'(cur_r.x1) >> 8);
      4'd4:  hb = 8'(cur_r.x1);
      4'd5:  begin hb = CMD_ROW_SET; hd = 1'b0; end
      4'd6:  hb = {4'd0, ry0[11:8]};
      4'd7:  hb = ry0[7:0];
      4'd8:  hb = {4'd0, ry1[11:8]};
      4'd9:  hb = ry1[7:0];
      default: begin hb = CMD_MEMORY_WRITE; hd = 1'b0; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_CLR:  if (32'(addr_r) == DEPTH - 1) state_nxt = BK_IDLE;
      BK_IDLE: if (req_valid) begin
        unique case (req.op)
          OP_FILL:   state_nxt = BK_FILL;
          OP_WINDOW: state_nxt = BK_HDR;
          OP_EMIT:   state_nxt = busy_r ? BK_RD : BK_IDLE;
          OP_CLEAR:  state_nxt = BK_IDLE;
        endcase
      end
      BK_FILL: if (col_r == cur_r.x1 && row_r == cur_r.y1) state_nxt = BK_IDLE;
      BK_HDR:  if (fire && hdr_r == 4'd10) state_nxt = BK_IDLE;
      BK_RD:   state_nxt = BK_PX_HI;
      BK_PX_HI: if (fire) state_nxt = BK_PX_LO;
      BK_PX_LO: if (fire) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    req_ready          = state_r == BK_IDLE;
    out_ch.valid       = 1'b0;
    out_ch.out_byte    = hb;
    out_ch.is_data     = hd;
    out_ch.run_last    = 1'b0;
    out_ch.window_done = 1'b0;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = cur_r.color;
    unique case (state_r)
      BK_CLR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      BK_FILL: wr_en = 1'b1;
      BK_HDR: begin
        out_ch.valid    = 1'b1;
        out_ch.run_last = hdr_r == 4'd10;
      end
      BK_PX_HI: begin
        out_ch.valid    = 1'b1;
        out_ch.out_byte = rd_data_r[15:8];
        out_ch.is_data  = 1'b1;
      end
      BK_PX_LO: begin
        out_ch.valid       = 1'b1;
        out_ch.out_byte    = rd_data_r[7:0];
        out_ch.is_data     = 1'b1;
        out_ch.run_last    = 1'b1;
        out_ch.window_done = done_r;
      end
      default: ;
    endcase
  end

  // window cursor always stays on screen after clipping
  assign rd_addr = AW'(32'(wt_r + cr_r) * SCREEN_WIDTH + 32'(wl_r + cc_r));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (state_r == BK_RD) rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_CLR;
      addr_r  <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        BK_CLR: addr_r <= addr_r + 1'b1;
        BK_IDLE: if (req_valid) begin
          cur_r <= req;
          col_r <= req.x0;
          row_r <= req.y0;
          hdr_r <= '0;
          if (req.op == OP_EMIT) begin
            addr_r <= rd_addr;
          end else begin
            addr_r <= AW'(32'(req.y0) * SCREEN_WIDTH + 32'(req.x0));
          end
          if (req.op == OP_CLEAR) busy_r <= 1'b0;
          if (req.op == OP_EMIT && busy_r) begin
            done_r <= (cc_r == wr_r) && (cr_r == wb_r);
            if (cc_r == wr_r) begin
              cc_r <= '0;
              if (cr_r == wb_r) begin
                cr_r   <= '0;
                busy_r <= 1'b0;
              end else begin
                cr_r <= cr_r + 1'b1;
              end
            end else begin
              cc_r <= cc_r + 1'b1;
            end
          end
        end
        BK_FILL: begin
          if (col_r == cur_r.x1) begin
            col_r  <= cur_r.x0;
            row_r  <= row_r + 1'b1;
            addr_r <= AW'(32'(row_r + 1'b1) * SCREEN_WIDTH + 32'(cur_r.x0));
          end else begin
            col_r  <= col_r + 1'b1;
            addr_r <= addr_r + 1'b1;
          end
        end
        BK_HDR: if (fire) begin
          hdr_r <= hdr_r + 1'b1;
          if (hdr_r == 4'd10) begin
            busy_r <= 1'b1;
            wl_r <= cur_r.x0;
            wt_r <= cur_r.y0;
            wr_r <= cur_r.x1 - cur_r.x0;
            wb_r <= cur_r.y1 - cur_r.y0;
            cc_r <= '0;
            cr_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> design/framebuffer_flush_engine_core.sv
// ----------------------------------------------------------------------------
// framebuffer_flush_engine_core: RGB565 frame store with panel window writer
//
// in_ch carries one action request (draw, rectangle fill, screen fill,
// start window, emit pixel). out_ch carries panel bytes with a data/command
// flag, a last-of-request mark and an end-of-window mark. cfg_ch writes
// row_offset (reset 35); write it only while the block is idle.
// A decode stage clips requests and hands them through a two-entry queue to
// the execution stage, which owns the single-port frame store.
// The execution stage takes each request from the queue in its idle state:
// a draw or fill then writes each clipped pixel into the store; a window
// start sends 11 header bytes at one per cycle while the receiver is ready;
// an emit reads the next window pixel from the store, then sends its high
// and low bytes, or sends nothing when no window is open.
// After reset all SCREEN_WIDTH*SCREEN_HEIGHT words of the store (54400 by
// default) are cleared before requests leave the queue.
// A stalled receiver holds the current byte; the queue fills, then in_ch
// deasserts ready.
// ----------------------------------------------------------------------------
module framebuffer_flush_engine_core import ffe_pkg::*; #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 170
) (
  input  logic       clk,
  input  logic       rst_n,
  ffe_in_if.sink     in_ch,
  ffe_out_if.source  out_ch,
  ffe_cfg_if.sink    cfg_ch
);

  logic [8:0] row_offset_r;
  logic       f_valid, f_ready, q_valid, q_ready;
  req_t       f_req, q_req;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_offset_r <= 9'd35;
    end else if (cfg_ch.valid) begin
      row_offset_r <= cfg_ch.data;
    end
  end

  ffe_front #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_front (
    .clk, .rst_n, .in_ch,
    .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
  );

  ffe_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  ffe_back #(.SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)) u_back (
    .clk, .rst_n, .row_offset(row_offset_r),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req), .out_ch
  );

endmodule

>>> tb/framebuffer_flush_engine_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// framebuffer_flush_engine_core_test: self-checking bench for the flush engine
// Sends draw, fill, window and emit requests, keeps a shadow frame store and
// window state, and checks each panel byte in order against the prediction.
// ----------------------------------------------------------------------------
module framebuffer_flush_engine_core_test;
  import ffe_pkg::*;

  localparam int SCR_W      = 320;
  localparam int SCR_H      = 170;
  localparam int HOLD_LEN   = 600;
  localparam int STALL_MAX  = 300000;
  localparam int DRAIN_WAIT = 40;

  typedef struct {
    logic [2:0]         action;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] w;
    logic signed [11:0] h;
    logic [15:0]        color;
  } flush_req_t;

  typedef struct {
    logic [7:0] data;
    logic       is_data;
    logic       last;
    logic       done;
  } panel_byte_t;

  logic clk;
  logic rst_n;

  ffe_in_if  in_ch ();
  ffe_out_if out_ch ();
  ffe_cfg_if cfg_ch ();

  framebuffer_flush_engine_core #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // shadow of the block
  logic [15:0] shadow_fb [0:SCR_W*SCR_H-1];
  logic [8:0]  shadow_row_offset;
  logic        shadow_busy;
  int          shadow_left, shadow_top, shadow_cols, shadow_rows;
  int          shadow_ccol, shadow_crow;

  flush_req_t  pending_reqs[$];
  panel_byte_t panel_bytes_due[$];
  flush_req_t  cur_req;

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  bit hold_seen;
  int hold_left;
  bit failed;
  int stall_cycles;
  int screen_fills;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit clip_to_screen(inout int x, inout int y, inout int w, inout int h);
    if (x < 0) begin
      w += x;
      x = 0;
    end
    if (y < 0) begin
      h += y;
      y = 0;
    end
    if (x + w > SCR_W) w = SCR_W - x;
    if (y + h > SCR_H) h = SCR_H - y;
    return (w > 0) && (h > 0);
  endfunction

  function automatic panel_byte_t mk_byte(int v, bit d, bit l, bit dn);
    panel_byte_t b;
    b.data    = v[7:0];
    b.is_data = d;
    b.last    = l;
    b.done    = dn;
    return b;
  endfunction

  task automatic predict_request(flush_req_t r);
    int x, y, w, h, x1, ry0, ry1, px;
    bit done;
    x = int'(r.x);
    y = int'(r.y);
    w = int'(r.w);
    h = int'(r.h);
    case (r.action)
      ACT_DRAW: begin
        if (x >= 0 && x < SCR_W && y >= 0 && y < SCR_H) shadow_fb[y*SCR_W + x] = r.color;
      end
      ACT_RECT: begin
        if (clip_to_screen(x, y, w, h))
          for (int rr = 0; rr < h; rr++)
            for (int cc = 0; cc < w; cc++) shadow_fb[(y+rr)*SCR_W + x + cc] = r.color;
      end
      ACT_SCREEN: begin
        for (int i = 0; i < SCR_W*SCR_H; i++) shadow_fb[i] = r.color;
      end
      ACT_WINDOW: begin
        if (!clip_to_screen(x, y, w, h)) begin
          shadow_busy = 1'b0;
        end else begin
          x1  = x + w - 1;
          ry0 = y + int'(shadow_row_offset);
          ry1 = y + h - 1 + int'(shadow_row_offset);
          panel_bytes_due.push_back(mk_byte(32'(CMD_COLUMN_SET), 1'b0, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(x >> 8, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(x, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(x1 >> 8, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(x1, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(32'(CMD_ROW_SET), 1'b0, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(ry0 >> 8, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(ry0, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(ry1 >> 8, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(ry1, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(32'(CMD_MEMORY_WRITE), 1'b0, 1'b1, 1'b0));
          shadow_left = x;
          shadow_top  = y;
          shadow_cols = w;
          shadow_rows = h;
          shadow_ccol = 0;
          shadow_crow = 0;
          shadow_busy = 1'b1;
        end
      end
      ACT_EMIT: begin
        if (shadow_busy) begin
          px   = 32'(shadow_fb[(shadow_top + shadow_crow)*SCR_W + shadow_left + shadow_ccol]);
          done = 1'b0;
          shadow_ccol++;
          if (shadow_ccol >= shadow_cols) begin
            shadow_ccol = 0;
            shadow_crow++;
            if (shadow_crow >= shadow_rows) begin
              done        = 1'b1;
              shadow_crow = 0;
              shadow_busy = 1'b0;
            end
          end
          panel_bytes_due.push_back(mk_byte(px >> 8, 1'b1, 1'b0, 1'b0));
          panel_bytes_due.push_back(mk_byte(px, 1'b1, 1'b1, done));
        end
      end
      default: ;  // unused codes: no bytes
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_request(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_ch.action      <= cur_req.action;
          in_ch.pos_x       <= cur_req.x;
          in_ch.pos_y       <= cur_req.y;
          in_ch.rect_width  <= cur_req.w;
          in_ch.rect_height <= cur_req.h;
          in_ch.pixel_color <= cur_req.color;
          in_ch.valid       <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // byte checker
  always @(posedge clk) begin
    panel_byte_t exp_b;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (panel_bytes_due.size() == 0) begin
        $display("%0t: unexpected byte %h is_data %b last %b done %b", $time,
                 out_ch.out_byte, out_ch.is_data, out_ch.run_last, out_ch.window_done);
        failed = 1'b1;
      end else begin
        exp_b = panel_bytes_due.pop_front();
        if (out_ch.out_byte !== exp_b.data || out_ch.is_data !== exp_b.is_data ||
            out_ch.run_last !== exp_b.last || out_ch.window_done !== exp_b.done) begin
          $display("%0t: byte mismatch expected %h/%b/%b/%b actual %h/%b/%b/%b", $time,
                   exp_b.data, exp_b.is_data, exp_b.last, exp_b.done, out_ch.out_byte,
                   out_ch.is_data, out_ch.run_last, out_ch.window_done);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic add_req(logic [2:0] a, int x, int y, int w, int h, int c);
    flush_req_t r;
    r.action = a;
    r.x      = 12'(x);
    r.y      = 12'(y);
    r.w      = 12'(w);
    r.h      = 12'(h);
    r.color  = 16'(c);
    pending_reqs.push_back(r);
  endtask

  task automatic write_row_offset(logic [8:0] v);
    @(posedge clk);
    cfg_ch.data  <= v;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    shadow_row_offset = v;
    cfg_ch.valid <= 1'b0;
  endtask

  // end each batch on a window so that drained bytes mean the block is idle;
  // sample between edges so the driver's updates have settled
  task automatic drain_batch();
    add_req(ACT_WINDOW, 5, 7, 1, 1, 0);
    while (pending_reqs.size() > 0 || in_ch.valid) @(negedge clk);
    while (panel_bytes_due.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic add_random_reqs(int count);
    int made, pick, x, y, w, h, cx, cy, cw, ch, n;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        x = int'($urandom_range(339)) - 10;
        y = int'($urandom_range(189)) - 10;
        w = $urandom_range(8, 1);
        h = $urandom_range(8, 1);
        add_req(ACT_WINDOW, x, y, w, h, $urandom);
        made++;
        cx = x; cy = y; cw = w; ch = h;
        n = clip_to_screen(cx, cy, cw, ch) ? cw * ch : 0;
        // cut short now and then, or run past the end
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        else if ($urandom_range(9) == 0) n += 2;
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(4) == 0) begin
            add_req(ACT_DRAW, cx + $urandom_range(7), cy + $urandom_range(7), 0, 0, $urandom);
            made++;
          end
          add_req(ACT_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
          made++;
        end
      end else if (pick < 63) begin
        add_req(ACT_DRAW, int'($urandom_range(335)) - 8, int'($urandom_range(185)) - 8,
                $urandom, $urandom, $urandom);
        made++;
      end else if (pick < 78) begin
        add_req(ACT_RECT, int'($urandom_range(339)) - 10, int'($urandom_range(189)) - 10,
                int'($urandom_range(24)) - 2, int'($urandom_range(24)) - 2, $urandom);
        made++;
      end else if (pick < 79) begin
        add_req(ACT_RECT, $urandom, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (pick < 88) begin
        add_req(ACT_EMIT, $urandom, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (pick < 93) begin
        add_req(ACT_WINDOW, $urandom, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (pick < 98) begin
        add_req(3'($urandom_range(7, 5)), $urandom, $urandom, $urandom, $urandom, $urandom);
        made++;
      end else if (screen_fills < 2) begin
        add_req(ACT_SCREEN, $urandom, $urandom, $urandom, $urandom, $urandom);
        screen_fills++;
        made++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    failed        = 1'b0;
    hold_req      = 1'b0;
    screen_fills  = 0;
    send_idle_pct = 23;
    recv_idle_pct = 50;
    in_ch.valid   = 1'b0;
    in_ch.action  = ACT_DRAW;
    in_ch.pos_x   = '0;
    in_ch.pos_y   = '0;
    in_ch.rect_width  = '0;
    in_ch.rect_height = '0;
    in_ch.pixel_color = '0;
    out_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    shadow_row_offset = 9'd35;
    shadow_busy   = 1'b0;
    shadow_left = 0; shadow_top = 0; shadow_cols = 0; shadow_rows = 0;
    shadow_ccol = 0; shadow_crow = 0;
    for (int i = 0; i < SCR_W*SCR_H; i++) shadow_fb[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_row_offset(9'd0);
    // directed: store corners, clipping, window corner cases
    add_req(ACT_DRAW, 0, 0, 0, 0, 16'hFFFF);
    add_req(ACT_DRAW, SCR_W-1, SCR_H-1, 0, 0, 16'h1234);
    add_req(ACT_DRAW, -1, 0, 0, 0, 16'hAAAA);
    add_req(ACT_DRAW, SCR_W, 5, 0, 0, 16'h5555);
    add_req(ACT_DRAW, -2048, 2047, 0, 0, 16'h0F0F);
    add_req(ACT_RECT, -5, -5, 10, 10, 16'hF0F0);
    add_req(ACT_RECT, 10, 10, -2048, 5, 16'hBEEF);
    add_req(ACT_RECT, 300, 160, 2047, 2047, 16'h8001);
    add_req(ACT_WINDOW, 318, 168, 10, 10, 0);
    repeat (5) add_req(ACT_EMIT, 0, 0, 0, 0, 0);  // last one finds no window
    add_req(ACT_WINDOW, -10, 0, 5, 5, 0);
    add_req(ACT_EMIT, 0, 0, 0, 0, 0);
    add_req(ACT_WINDOW, 0, 0, 3, 3, 0);
    repeat (2) add_req(ACT_EMIT, 0, 0, 0, 0, 0);
    add_req(ACT_WINDOW, -2048, -2048, 2047, 2049, 0);
    add_req(ACT_DRAW, 0, 0, 0, 0, 16'hC3C3);
    add_req(ACT_EMIT, 0, 0, 0, 0, 0);
    add_req(ACT_SCREEN, 0, 0, 0, 0, 16'h0000);
    add_req(3'd5, 0, 0, 0, 0, 0);
    add_req(3'd7, -1, -1, -1, -1, 16'hFFFF);
    drain_batch();
    add_random_reqs(130);
    drain_batch();

    write_row_offset(9'd319);
    send_idle_pct = 50;
    recv_idle_pct = 23;
    add_random_reqs(130);
    drain_batch();

    write_row_offset(9'($urandom_range(318, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;  // stall the panel side while requests keep coming
    add_random_reqs(130);
    drain_batch();

    write_row_offset(9'd35);
    add_req(ACT_WINDOW, SCR_W-2, SCR_H-2, 2, 2, 0);
    repeat (4) add_req(ACT_EMIT, 0, 0, 0, 0, 0);
    drain_batch();

    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
